@@ rtl/core/bnsg_pkg.sv @@
`timescale 1ns / 1ps

package bnsg_pkg;

  typedef enum logic [2:0] {
    OP_INIT = 3'd0,
    OP_ACC  = 3'd1,
    OP_UPD  = 3'd2,
    OP_SCL  = 3'd3,
    OP_READ = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_INIT,
    ST_RD,
    ST_MUL,
    ST_WR,
    ST_RPT_RD,
    ST_RPT_OUT
  } state_t;

  typedef struct packed {
    logic in_load;
    logic cnt_clr;
    logic cnt_inc;
    logic rd_en;
    logic addr_ch;
    logic mul_en;
    logic clr_wr;
    logic init_wr;
    logic op_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       ch_ok;
    logic       n_zero;
    logic       cnt_last;
    logic       clr_last;
    logic       out_free;
  } status_t;

  localparam int QW = 32;
  localparam int PW = 48;
  localparam int SW = 49;
  localparam int CFG_W = 7;
  localparam int CH_W = 6;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

endpackage

@@ rtl/core/bnsg_ctrl.sv @@
`timescale 1ns / 1ps

module bnsg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bnsg_pkg::status_t  status,
  output bnsg_pkg::cmd_t     cmd
);

  bnsg_pkg::state_t state;
  bnsg_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bnsg_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      bnsg_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status.clr_last) begin
          cmd.cnt_inc = 1'b0;
          cmd.cnt_clr = 1'b1;
          state_next = bnsg_pkg::ST_IDLE;
        end
      end
      bnsg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next = bnsg_pkg::ST_DECODE;
        end
      end
      bnsg_pkg::ST_DECODE: begin
        cmd.cnt_clr = 1'b1;
        case (status.op)
          bnsg_pkg::OP_INIT:
            state_next = status.n_zero ? bnsg_pkg::ST_RPT_RD : bnsg_pkg::ST_INIT;
          bnsg_pkg::OP_ACC:
            state_next = status.ch_ok ? bnsg_pkg::ST_RD : bnsg_pkg::ST_RPT_RD;
          bnsg_pkg::OP_UPD, bnsg_pkg::OP_SCL:
            state_next = status.n_zero ? bnsg_pkg::ST_RPT_RD : bnsg_pkg::ST_RD;
          default:
            state_next = bnsg_pkg::ST_RPT_RD;
        endcase
      end
      bnsg_pkg::ST_INIT: begin
        cmd.init_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status.cnt_last) begin
          state_next = bnsg_pkg::ST_RPT_RD;
        end
      end
      bnsg_pkg::ST_RD: begin
        cmd.rd_en = 1'b1;
        cmd.addr_ch = (status.op == bnsg_pkg::OP_ACC);
        state_next = bnsg_pkg::ST_MUL;
      end
      bnsg_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = bnsg_pkg::ST_WR;
      end
      bnsg_pkg::ST_WR: begin
        cmd.op_wr = 1'b1;
        if (status.op == bnsg_pkg::OP_ACC) begin
          cmd.addr_ch = 1'b1;
          state_next = bnsg_pkg::ST_RPT_RD;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next = status.cnt_last ? bnsg_pkg::ST_RPT_RD : bnsg_pkg::ST_RD;
        end
      end
      bnsg_pkg::ST_RPT_RD: begin
        cmd.rd_en = 1'b1;
        cmd.addr_ch = 1'b1;
        state_next = bnsg_pkg::ST_RPT_OUT;
      end
      bnsg_pkg::ST_RPT_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = bnsg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bnsg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/bnsg_datapath.sv @@
`timescale 1ns / 1ps

module bnsg_datapath #(
  parameter int CHANNELS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bnsg_pkg::cmd_t                   cmd,
  output bnsg_pkg::status_t                status,
  input  logic                             cfg_we,
  input  logic [bnsg_pkg::CFG_W-1:0]       cfg_data,
  input  logic [2:0]                       operation,
  input  logic [bnsg_pkg::CH_W-1:0]        channel,
  input  logic signed [bnsg_pkg::QW-1:0]   delta,
  input  logic signed [bnsg_pkg::QW-1:0]   normalized,
  input  logic signed [bnsg_pkg::QW-1:0]   operand_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bnsg_pkg::CH_W-1:0]        out_channel,
  output logic signed [bnsg_pkg::QW-1:0]   scale_value,
  output logic signed [bnsg_pkg::QW-1:0]   gradient_value,
  output logic                             overflowed
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW = $clog2(CHANNELS + 1);
  localparam int NW = (CW > bnsg_pkg::CFG_W) ? CW : bnsg_pkg::CFG_W;
  localparam int QW = bnsg_pkg::QW;
  localparam int PW = bnsg_pkg::PW;
  localparam int SW = bnsg_pkg::SW;

  logic signed [QW-1:0] scale_mem [CHANNELS];
  logic signed [QW-1:0] grad_mem  [CHANNELS];

  logic [bnsg_pkg::CFG_W-1:0] active;
  logic [2:0]                 op_q;
  logic [bnsg_pkg::CH_W-1:0]  ch_q;
  logic signed [QW-1:0]       delta_q;
  logic signed [QW-1:0]       norm_q;
  logic signed [QW-1:0]       opv_q;
  logic [CW-1:0]              cnt;
  logic signed [QW-1:0]       scale_rd;
  logic signed [QW-1:0]       grad_rd;
  logic signed [PW-1:0]       prod_q;
  logic                       ovf;

  logic [NW-1:0]              ch_ext;
  logic [NW-1:0]              act_ext;
  logic [NW-1:0]              n_eff;
  logic [AW-1:0]              addr;
  logic                       ch_ok;
  logic signed [QW-1:0]       mul_a;
  logic signed [QW-1:0]       mul_b;
  logic signed [2*QW-1:0]     prod_full;
  logic signed [SW-1:0]       sum;
  logic                       sat_hi;
  logic                       sat_lo;
  logic signed [QW-1:0]       sat_val;
  logic                       is_acc;
  logic                       is_upd;
  logic                       is_scl;
  logic                       scale_we;
  logic                       grad_we;
  logic signed [QW-1:0]       scale_wd;

  assign is_acc = (op_q == bnsg_pkg::OP_ACC);
  assign is_upd = (op_q == bnsg_pkg::OP_UPD);
  assign is_scl = (op_q == bnsg_pkg::OP_SCL);

  assign ch_ext  = NW'(ch_q);
  assign act_ext = NW'(active);
  assign n_eff   = (act_ext > NW'(CHANNELS)) ? NW'(CHANNELS) : act_ext;
  assign ch_ok   = (ch_ext < NW'(CHANNELS));
  assign addr    = cmd.addr_ch ? ch_ext[AW-1:0] : cnt[AW-1:0];

  assign status.op       = op_q;
  assign status.ch_ok    = ch_ok;
  assign status.n_zero   = (n_eff == '0);
  assign status.cnt_last = ((NW'(cnt) + NW'(1)) == n_eff);
  assign status.clr_last = (cnt == CW'(CHANNELS - 1));
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= bnsg_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      active <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_q    <= operation;
      ch_q    <= channel;
      delta_q <= delta;
      norm_q  <= normalized;
      opv_q   <= operand_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CW'(1);
    end
  end

  // shared multiplier; arithmetic shift gives the floor of the Q16.16 product
  assign mul_a     = is_acc ? delta_q : opv_q;
  assign mul_b     = is_acc ? norm_q : grad_rd;
  assign prod_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_q <= prod_full[2*QW-1:16];
    end
  end

  always_comb begin
    case (op_q)
      bnsg_pkg::OP_ACC: sum = {{(SW-QW){grad_rd[QW-1]}}, grad_rd} + {prod_q[PW-1], prod_q};
      bnsg_pkg::OP_UPD: sum = {{(SW-QW){scale_rd[QW-1]}}, scale_rd} + {prod_q[PW-1], prod_q};
      default:          sum = {prod_q[PW-1], prod_q};
    endcase
  end

  assign sat_hi  = !sum[SW-1] && (sum[SW-2:QW-1] != '0);
  assign sat_lo  = sum[SW-1] && (sum[SW-2:QW-1] != '1);
  assign sat_val = sat_hi ? {1'b0, {(QW-1){1'b1}}} :
                   sat_lo ? {1'b1, {(QW-1){1'b0}}} : sum[QW-1:0];

  assign scale_we = cmd.clr_wr || cmd.init_wr || (cmd.op_wr && is_upd);
  assign grad_we  = cmd.clr_wr || (cmd.op_wr && (is_acc || is_scl));
  assign scale_wd = cmd.clr_wr ? '0 : (cmd.init_wr ? opv_q : sat_val);

  always_ff @(posedge clk) begin
    if (scale_we) begin
      scale_mem[addr] <= scale_wd;
    end
    if (cmd.rd_en) begin
      scale_rd <= scale_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (grad_we) begin
      grad_mem[addr] <= cmd.clr_wr ? '0 : sat_val;
    end
    if (cmd.rd_en) begin
      grad_rd <= grad_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      ovf <= 1'b0;
    end else if (cmd.op_wr && (sat_hi || sat_lo)) begin
      ovf <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel    <= ch_q;
      scale_value    <= ch_ok ? scale_rd : '0;
      gradient_value <= ch_ok ? grad_rd : '0;
      overflowed     <= ovf;
    end
  end

endmodule

@@ rtl/core/batchnorm_scale_grad_accumulator.sv @@
`timescale 1ns / 1ps
// One item at a time; operations are read, accumulate, init, update and gradient
// scale. The next item is taken in the cycle after the result is loaded.
// Update and gradient scale sweep the active channels with a read, multiply,
// write-back step per channel over the single-port stores.
// Synchronous reset; a clearing pass zeroes both stores, during which no item
// is taken. active_channels resets to 64.

module batchnorm_scale_grad_accumulator #(
  parameter int CHANNELS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bnsg_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       operation,
  input  logic [bnsg_pkg::CH_W-1:0]        channel,
  input  logic signed [bnsg_pkg::QW-1:0]   delta,
  input  logic signed [bnsg_pkg::QW-1:0]   normalized,
  input  logic signed [bnsg_pkg::QW-1:0]   operand_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bnsg_pkg::CH_W-1:0]        out_channel,
  output logic signed [bnsg_pkg::QW-1:0]   scale_value,
  output logic signed [bnsg_pkg::QW-1:0]   gradient_value,
  output logic                             overflowed
);

  bnsg_pkg::cmd_t    cmd;
  bnsg_pkg::status_t status;

  assign cfg_ready = 1'b1;

  bnsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bnsg_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .channel        (channel),
    .delta          (delta),
    .normalized     (normalized),
    .operand_value  (operand_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .scale_value    (scale_value),
    .gradient_value (gradient_value),
    .overflowed     (overflowed)
  );

endmodule
